// File: rtl/gld_pkg.sv
`default_nettype none
package gld_pkg;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_POP   = 7'b0000100,
    ST_CODE  = 7'b0001000,
    ST_EXP   = 7'b0010000,
    ST_WALK  = 7'b0100000,
    ST_LAST  = 7'b1000000
  } state_t;

  localparam logic [1:0] OP_FEED    = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_REQ     = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [2:0] STS_PIXEL     = 3'd0;
  localparam logic [2:0] STS_NEED_DATA = 3'd1;
  localparam logic [2:0] STS_END_CODE  = 3'd2;
  localparam logic [2:0] STS_PREMATURE = 3'd3;
  localparam logic [2:0] STS_LOOP      = 3'd4;
  localparam logic [2:0] STS_REFUSED   = 3'd5;

  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;
  localparam int         LIT_ENTRIES    = 256;
  localparam logic [5:0] FEED_LIMIT     = 6'd24;

endpackage
`default_nettype wire

// File: rtl/gif_lzw_decoder.sv
`default_nettype none
// GIF LZW decoder with variable code width.
// Command channel: an item (op, data_byte) is taken when start is high and
// busy is low. Feed loads a byte into the 32-bit bit buffer, LSB first;
// end-of-stream mark and restart give no result.
// Request gives exactly one result; a refused feed gives one result too.
// A result sits on pixel_index/status for one cycle with done high, the
// cycle after the item finishes; the receiver cannot stall it.
// Steps: feed, mark and restart are handled in the idle state; a stack
// pop passes through ST_POP; a request that reads codes stays in ST_CODE
// while it reads clear codes, then walks the chain in ST_EXP and ST_WALK,
// one string element per step (prefix/suffix memory read loop), and
// updates the table in ST_LAST; the table walk does one read per cycle.
// The pixel stack memory holds the rest of an expanded string; later
// requests pop it, one item per request.
// Reset: the block runs a pass that writes the 256 literal table
// entries (prefix 0, suffix i); busy stays high meanwhile. Configuration
// writes (cfg_valid/cfg_ready, min_code_size in cfg_data) are always taken.
module gif_lzw_decoder #(
  parameter int MAX_CODE_BITS = 12,
  parameter int STACK_DEPTH   = 8192
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] op,
  input  wire logic [7:0] data_byte,
  output logic            done,
  output logic [7:0]      pixel_index,
  output logic [2:0]      status,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [3:0] cfg_data
);

  localparam int TW  = MAX_CODE_BITS;          // table address bits
  localparam int NW  = MAX_CODE_BITS + 1;      // slot / limit / step counter
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = SAW + 1;
  localparam logic [NW-1:0]  TABLE_SIZE = NW'(1) << MAX_CODE_BITS;
  localparam logic [SPW-1:0] STACK_FULL = SPW'(STACK_DEPTH);
  localparam logic [3:0]     WIDTH_MAX  = 4'(MAX_CODE_BITS);

  gld_pkg::state_t state;

  logic [3:0]     min_code_size;
  logic [31:0]    bit_buffer;
  logic [5:0]     bits_held;
  logic           stream_ended;
  logic           finished;
  logic [3:0]     current_width;
  logic [NW-1:0]  width_limit;
  logic [NW-1:0]  next_slot;
  logic           fresh_flag;
  logic [7:0]     first_value;
  logic [TW-1:0]  previous_code;
  logic [TW-1:0]  code_hold;
  logic [TW-1:0]  walk;
  logic [NW-1:0]  steps;
  logic           loop_flag;
  logic [SPW-1:0] stack_pointer;
  logic [8:0]     sweep;

  // memory ports
  logic          tab_we;
  logic [TW-1:0] tab_waddr;
  logic [TW-1:0] tab_wprefix;
  logic [7:0]    tab_wsuffix;
  logic [TW-1:0] tab_raddr;
  logic [TW-1:0] prefix_rdata;
  logic [7:0]    suffix_rdata;
  logic          stk_we;
  logic [7:0]    stk_wdata;
  logic [SAW-1:0] stk_raddr;
  logic [7:0]    stk_rdata;

  // decode helpers
  logic [3:0]    data_bits;
  logic [8:0]    clr_code;
  logic [8:0]    max_data;
  logic [31:0]   code_mask;
  logic [TW-1:0] code;
  logic          enough;
  logic [TW-1:0] dec_w;
  logic          deeper;
  logic          loop_hit;
  logic          stack_room;
  logic [NW-1:0] slot_inc;

  assign cfg_ready  = 1'b1;
  assign busy       = (state != gld_pkg::ST_IDLE);
  assign stack_room = (stack_pointer < STACK_FULL);

  always_comb begin
    data_bits = min_code_size;
    if (data_bits < 4'd1) data_bits = 4'd1;
    if (data_bits > 4'd8) data_bits = 4'd8;
    clr_code   = 9'd1 << data_bits;
    max_data   = clr_code - 9'd1;
    code_mask  = (32'd1 << current_width) - 32'd1;
    code       = bit_buffer[TW-1:0] & code_mask[TW-1:0];
    enough     = (bits_held >= {2'b00, current_width});
    // walk step input: the start point, or the prefix just read
    dec_w      = (state == gld_pkg::ST_WALK) ? prefix_rdata : walk;
    deeper     = ({{(NW-TW){1'b0}}, dec_w} > NW'(max_data));
    loop_hit   = deeper && (steps > TABLE_SIZE);
    slot_inc   = next_slot + NW'(1);
  end

  // table port: literal sweep after reset, else the new entry in ST_LAST
  always_comb begin
    tab_we      = 1'b0;
    tab_waddr   = next_slot[TW-1:0];
    tab_wprefix = previous_code;
    tab_wsuffix = suffix_rdata;
    tab_raddr   = dec_w;
    if (state == gld_pkg::ST_CLEAR) begin
      tab_we      = 1'b1;
      tab_waddr   = TW'(sweep[7:0]);
      tab_wprefix = '0;
      tab_wsuffix = sweep[7:0];
    end else if (state == gld_pkg::ST_LAST) begin
      tab_we = (next_slot < TABLE_SIZE);
    end
  end

  // stack port: push the KwKwK first value or each suffix of the walk
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = suffix_rdata;
    stk_raddr = SAW'(stack_pointer - SPW'(1));
    if (state == gld_pkg::ST_CODE && enough && code != TW'(clr_code) &&
        code != TW'(clr_code + 9'd1) && !fresh_flag &&
        {1'b0, code} >= next_slot) begin
      stk_we    = stack_room;
      stk_wdata = first_value;
    end else if (state == gld_pkg::ST_WALK) begin
      stk_we = stack_room;
    end
  end

  gld_ram #(.WIDTH(TW), .DEPTH(1 << MAX_CODE_BITS)) u_prefix (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wprefix),
    .raddr(tab_raddr), .rdata(prefix_rdata)
  );

  gld_ram #(.WIDTH(8), .DEPTH(1 << MAX_CODE_BITS)) u_suffix (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wsuffix),
    .raddr(tab_raddr), .rdata(suffix_rdata)
  );

  gld_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stack_pointer[SAW-1:0]), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gld_pkg::ST_CLEAR;
      sweep         <= '0;
      min_code_size <= gld_pkg::MIN_SIZE_RESET;
      bit_buffer    <= '0;
      bits_held     <= '0;
      stream_ended  <= 1'b0;
      finished      <= 1'b0;
      current_width <= 4'd9;
      width_limit   <= NW'(512);
      next_slot     <= NW'(258);
      fresh_flag    <= 1'b1;
      first_value   <= '0;
      previous_code <= '0;
      stack_pointer <= '0;
      done          <= 1'b0;
      loop_flag     <= 1'b0;
      steps         <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        min_code_size <= cfg_data;
      end
      unique case (state)
        gld_pkg::ST_CLEAR: begin
          sweep <= sweep + 9'd1;
          if (sweep == 9'(gld_pkg::LIT_ENTRIES - 1)) state <= gld_pkg::ST_IDLE;
        end
        gld_pkg::ST_IDLE: begin
          if (start) begin
            unique case (op)
              gld_pkg::OP_FEED: begin
                if (stream_ended || bits_held > gld_pkg::FEED_LIMIT) begin
                  done        <= 1'b1;
                  pixel_index <= '0;
                  status      <= gld_pkg::STS_REFUSED;
                end else begin
                  bit_buffer <= bit_buffer | ({24'd0, data_byte} << bits_held);
                  bits_held  <= bits_held + 6'd8;
                end
              end
              gld_pkg::OP_END: stream_ended <= 1'b1;
              gld_pkg::OP_RESTART: begin
                bit_buffer    <= '0;
                bits_held     <= '0;
                stream_ended  <= 1'b0;
                finished      <= 1'b0;
                first_value   <= '0;
                previous_code <= '0;
                stack_pointer <= '0;
                current_width <= data_bits + 4'd1;
                width_limit   <= NW'(1) << (data_bits + 4'd1);
                next_slot     <= NW'(clr_code) + NW'(2);
                fresh_flag    <= 1'b1;
              end
              gld_pkg::OP_REQ: begin
                if (stack_pointer != '0) begin
                  // pop: address sp-1 is on the read port now
                  stack_pointer <= stack_pointer - SPW'(1);
                  state         <= gld_pkg::ST_POP;
                end else if (finished) begin
                  done        <= 1'b1;
                  pixel_index <= '0;
                  status      <= gld_pkg::STS_END_CODE;
                end else begin
                  state <= gld_pkg::ST_CODE;
                end
              end
              default: ;
            endcase
          end
        end
        gld_pkg::ST_POP: begin
          done        <= 1'b1;
          pixel_index <= stk_rdata;
          status      <= gld_pkg::STS_PIXEL;
          state       <= gld_pkg::ST_IDLE;
        end
        gld_pkg::ST_CODE: begin
          if (!enough) begin
            done        <= 1'b1;
            pixel_index <= '0;
            status      <= stream_ended ? gld_pkg::STS_PREMATURE : gld_pkg::STS_NEED_DATA;
            state       <= gld_pkg::ST_IDLE;
          end else begin
            bit_buffer <= bit_buffer >> current_width;
            bits_held  <= bits_held - {2'b00, current_width};
            if (code == TW'(clr_code)) begin
              // reload widths and keep reading codes
              current_width <= data_bits + 4'd1;
              width_limit   <= NW'(1) << (data_bits + 4'd1);
              next_slot     <= NW'(clr_code) + NW'(2);
              fresh_flag    <= 1'b1;
            end else if (code == TW'(clr_code + 9'd1)) begin
              finished    <= 1'b1;
              done        <= 1'b1;
              pixel_index <= '0;
              status      <= gld_pkg::STS_END_CODE;
              state       <= gld_pkg::ST_IDLE;
            end else if (fresh_flag) begin
              done  <= 1'b1;
              state <= gld_pkg::ST_IDLE;
              if (code >= TW'(clr_code)) begin
                pixel_index <= '0;
                status      <= gld_pkg::STS_LOOP;
              end else begin
                fresh_flag    <= 1'b0;
                first_value   <= code[7:0];
                previous_code <= code;
                pixel_index   <= code[7:0];
                status        <= gld_pkg::STS_PIXEL;
              end
            end else begin
              code_hold <= code;
              steps     <= '0;
              state     <= gld_pkg::ST_EXP;
              if ({1'b0, code} < next_slot) begin
                walk <= code;
              end else begin
                // KwKwK: first value pushed by the stack port
                walk <= previous_code;
                if (stack_room) stack_pointer <= stack_pointer + SPW'(1);
              end
            end
          end
        end
        gld_pkg::ST_EXP, gld_pkg::ST_WALK: begin
          if (state == gld_pkg::ST_WALK && stack_room) begin
            stack_pointer <= stack_pointer + SPW'(1);
          end
          walk      <= dec_w;
          loop_flag <= loop_hit;
          if (deeper && !loop_hit) begin
            steps <= steps + NW'(1);
            state <= gld_pkg::ST_WALK;
          end else begin
            state <= gld_pkg::ST_LAST;
          end
        end
        gld_pkg::ST_LAST: begin
          first_value <= suffix_rdata;
          if (next_slot < TABLE_SIZE) begin
            next_slot <= slot_inc;
            if (slot_inc >= width_limit && current_width < WIDTH_MAX) begin
              current_width <= current_width + 4'd1;
              width_limit   <= NW'(1) << (current_width + 4'd1);
            end
          end
          previous_code <= code_hold;
          if (loop_flag) begin
            stack_pointer <= '0;
            done          <= 1'b1;
            pixel_index   <= '0;
            status        <= gld_pkg::STS_LOOP;
            state         <= gld_pkg::ST_IDLE;
          end else if (stack_room) begin
            // push of the first value and its pop cancel out
            done        <= 1'b1;
            pixel_index <= suffix_rdata;
            status      <= gld_pkg::STS_PIXEL;
            state       <= gld_pkg::ST_IDLE;
          end else begin
            stack_pointer <= stack_pointer - SPW'(1);
            state         <= gld_pkg::ST_POP;
          end
        end
        default: state <= gld_pkg::ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    stack_pointer <= STACK_FULL)
    else $error("stack pointer beyond stack depth");

  a_no_result_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == gld_pkg::ST_CLEAR) |=> !done)
    else $error("result during table sweep");

  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == gld_pkg::OP_REQ) |=> (busy || done))
    else $error("request dropped");
`endif

endmodule
`default_nettype wire

// File: rtl/gld_ram.sv
`default_nettype none
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: tb/gif_lzw_decoder_checker.sv
`timescale 1ns / 1ps
module gif_lzw_decoder_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic [1:0] op,
  input  wire logic [7:0] data_byte,
  input  wire logic       done,
  input  wire logic [7:0] pixel_index,
  input  wire logic [2:0] status,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [3:0] cfg_data,
  output int              fail_count,
  output int              pending,
  output int              checked,
  output logic [2:0]      last_status
);

  typedef struct packed {
    logic [7:0] pix;
    logic [2:0] sts;
  } pixel_result_t;

  pixel_result_t result_q[$];

  logic [3:0]  min_size;
  logic [31:0] bitbuf;
  int          held;
  bit          ended;
  bit          fin;
  int          width;
  int          wlimit;
  int          slot;
  bit          fresh;
  int          first_val;
  int          prev_code;
  bit [11:0]   prefix_mem [4096];
  bit [7:0]    suffix_mem [4096];
  bit [7:0]    pix_stack [8192];
  int          sp;

  function automatic int data_bits();
    int m;
    m = int'(min_size);
    if (m < 1) m = 1;
    if (m > 8) m = 8;
    return m;
  endfunction

  function automatic void reload_width();
    width  = data_bits() + 1;
    wlimit = 1 << width;
    slot   = (1 << data_bits()) + 2;
    fresh  = 1'b1;
  endfunction

  function automatic void restart_decode();
    bitbuf = '0;
    held = 0;
    ended = 1'b0;
    fin = 1'b0;
    first_val = 0;
    prev_code = 0;
    sp = 0;
    reload_width();
  endfunction

  function automatic void push_pixel(int v);
    if (sp < 8192) begin
      pix_stack[sp] = v[7:0];
      sp++;
    end
  endfunction

  // Walk the prefix chain onto the stack; return 0 when the chain loops.
  function automatic bit expand_string(int code);
    int max_data;
    int walk;
    int steps;
    bit looped;
    max_data = (1 << data_bits()) - 1;
    steps = 0;
    looped = 1'b0;
    if (code < slot) begin
      walk = code;
    end else begin
      push_pixel(first_val);
      walk = prev_code;
    end
    while (walk > max_data && !looped) begin
      if (steps > 4096) begin
        looped = 1'b1;
      end else begin
        steps++;
        push_pixel(suffix_mem[walk & 4095]);
        walk = prefix_mem[walk & 4095];
      end
    end
    first_val = suffix_mem[walk & 4095];
    push_pixel(first_val);
    if (slot < 4096) begin
      prefix_mem[slot] = prev_code[11:0];
      suffix_mem[slot] = first_val[7:0];
      slot++;
      if (slot >= wlimit && width < 12) begin
        width++;
        wlimit = 1 << width;
      end
    end
    prev_code = code & 4095;
    if (looped) sp = 0;
    return !looped;
  endfunction

  function automatic bit decode_item(logic [1:0] o, logic [7:0] b, output pixel_result_t r);
    int clr;
    int code;
    r.pix = '0;
    r.sts = gld_pkg::STS_PIXEL;
    if (o == gld_pkg::OP_FEED) begin
      if (ended || held > 24) begin
        r.sts = gld_pkg::STS_REFUSED;
        return 1'b1;
      end
      bitbuf = bitbuf | (32'(b) << held);
      held += 8;
      return 1'b0;
    end
    if (o == gld_pkg::OP_END) begin
      ended = 1'b1;
      return 1'b0;
    end
    if (o == gld_pkg::OP_RESTART) begin
      restart_decode();
      return 1'b0;
    end
    if (sp > 0) begin
      sp--;
      r.pix = pix_stack[sp];
    end else if (fin) begin
      r.sts = gld_pkg::STS_END_CODE;
    end else begin
      while (1) begin
        clr = 1 << data_bits();
        if (held < width) begin
          r.sts = ended ? gld_pkg::STS_PREMATURE : gld_pkg::STS_NEED_DATA;
          break;
        end
        code = int'(bitbuf) & ((1 << width) - 1);
        bitbuf = bitbuf >> width;
        held -= width;
        if (code == clr) begin
          reload_width();
          continue;
        end
        if (code == clr + 1) begin
          fin = 1'b1;
          r.sts = gld_pkg::STS_END_CODE;
          break;
        end
        if (fresh) begin
          if (code >= clr) begin
            r.sts = gld_pkg::STS_LOOP;
            break;
          end
          fresh = 1'b0;
          first_val = code;
          prev_code = code;
          r.pix = code[7:0];
          break;
        end
        if (!expand_string(code)) begin
          r.sts = gld_pkg::STS_LOOP;
          break;
        end
        sp--;
        r.pix = pix_stack[sp];
        break;
      end
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    pixel_result_t got;
    pixel_result_t want;
    if (rst) begin
      fail_count = 0;
      checked = 0;
      last_status = gld_pkg::STS_PIXEL;
      min_size = gld_pkg::MIN_SIZE_RESET;
      for (int i = 0; i < 4096; i++) begin
        prefix_mem[i] = '0;
        suffix_mem[i] = (i < gld_pkg::LIT_ENTRIES) ? i[7:0] : 8'd0;
      end
      restart_decode();
      result_q.delete();
    end else begin
      if (done) begin
        got.pix = pixel_index;
        got.sts = status;
        last_status = status;
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result pixel %0d status %0d", $time, got.pix, got.sts);
        end else begin
          want = result_q.pop_front();
          checked++;
          if (got.pix !== want.pix || got.sts !== want.sts) begin
            fail_count++;
            $display("%0t: mismatch expected pixel %0d status %0d, got pixel %0d status %0d",
                     $time, want.pix, want.sts, got.pix, got.sts);
          end
        end
      end
      if (cfg_valid && cfg_ready) min_size = cfg_data;
      if (start && !busy) begin
        if (decode_item(op, data_byte, want)) result_q.push_back(want);
      end
    end
    pending = result_q.size();
  end

endmodule

// File: tb/gif_lzw_decoder_tb.sv
`timescale 1ns / 1ps
module gif_lzw_decoder_tb;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic       done;
  logic [7:0] pixel_index;
  logic [2:0] status;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  int         fail_count;
  int         pending;
  int         checked;
  logic [2:0] last_status;

  // Stimulus bookkeeping.
  int         items_sent;
  int         streams;
  bit         no_idle;
  int         cur_cfg;

  // Encoder side: mirror the decoder's code width so codes pack correctly.
  int          enc_m;
  int          enc_width;
  int          enc_slot;
  bit          enc_fresh;
  int unsigned enc_acc;
  int          enc_bits;
  logic [7:0]  stream_bytes[$];

  gif_lzw_decoder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .data_byte(data_byte),
    .done(done), .pixel_index(pixel_index), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  gif_lzw_decoder_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .data_byte(data_byte),
    .done(done), .pixel_index(pixel_index), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .last_status(last_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int clamp_size(int v);
    if (v < 1) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic void enc_reload();
    enc_width = enc_m + 1;
    enc_slot  = (1 << enc_m) + 2;
    enc_fresh = 1'b1;
  endfunction

  // Pack one code LSB first and advance the width tracking the way the decoder does.
  function automatic void enc_code(int code);
    int clr;
    clr = 1 << enc_m;
    enc_acc = enc_acc | (code << enc_bits);
    enc_bits += enc_width;
    while (enc_bits >= 8) begin
      stream_bytes.push_back(enc_acc[7:0]);
      enc_acc = enc_acc >> 8;
      enc_bits -= 8;
    end
    if (code == clr) begin
      enc_reload();
    end else if (code == clr + 1) begin
      enc_fresh = enc_fresh;
    end else if (enc_fresh) begin
      if (code < clr) enc_fresh = 1'b0;
    end else if (enc_slot < 4096) begin
      enc_slot++;
      if (enc_slot >= (1 << enc_width) && enc_width < 12) enc_width++;
    end
  endfunction

  function automatic int pick_pixel(int alpha);
    if (alpha == 0) return $urandom_range(1, 0) ? (1 << enc_m) - 1 : 0;
    return $urandom_range(alpha - 1, 0);
  endfunction

  // Plain LZW compression of a random pixel run; optionally a bad first code and a clear halfway.
  function automatic void enc_lzw(int npix, int alpha, bit bad_first, bit mid_clear);
    int dict[int];
    int nxt;
    int w;
    int c;
    int clr;
    clr = 1 << enc_m;
    enc_code(clr);
    if (bad_first) enc_code(clr + 2);
    nxt = clr + 2;
    w = pick_pixel(alpha);
    for (int i = 1; i < npix; i++) begin
      c = pick_pixel(alpha);
      if (mid_clear && i == npix / 2) begin
        enc_code(w);
        enc_code(clr);
        dict.delete();
        nxt = clr + 2;
        w = c;
      end else if (dict.exists(w * 256 + c)) begin
        w = dict[w * 256 + c];
      end else begin
        enc_code(w);
        if (nxt < 4096) begin
          dict[w * 256 + c] = nxt;
          nxt++;
        end
        w = c;
      end
    end
    enc_code(w);
  endfunction

  // Build a self-referencing table entry, then hit it so the chain walk runs into a loop.
  function automatic void enc_loop();
    int clr;
    clr = 1 << enc_m;
    enc_code(clr);
    enc_code($urandom_range(clr - 1, 0));
    enc_code(enc_slot + 1);
    enc_code($urandom_range(clr - 1, 0));
    enc_code(enc_slot - 1);
  endfunction

  task automatic send(logic [1:0] o, logic [7:0] b);
    int g;
    g = idle_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    data_byte <= b;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Issue a request and hold until every outstanding result is in.
  task automatic request(output logic [2:0] s);
    send(gld_pkg::OP_REQ, 8'($urandom_range(255, 0)));
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    s = last_status;
    @(posedge clk);
  endtask

  // Drain everything, including work on items that give no result.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(int v);
    cfg_valid <= 1'b1;
    cfg_data <= 4'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_cfg = v;
  endtask

  // Pull pixels until the stream ends; feed bytes only when the block asks.
  task automatic play(bit post_noise);
    logic [2:0] s;
    forever begin
      request(s);
      if (s == gld_pkg::STS_END_CODE || s == gld_pkg::STS_PREMATURE) break;
      if (s == gld_pkg::STS_NEED_DATA) begin
        if (stream_bytes.size() > 0) begin
          send(gld_pkg::OP_FEED, stream_bytes.pop_front());
          if (stream_bytes.size() > 0 && $urandom_range(3, 0) == 0)
            send(gld_pkg::OP_FEED, stream_bytes.pop_front());
        end else begin
          // Out of data: mark the end, then try one more byte, which must bounce.
          send(gld_pkg::OP_END, 8'($urandom_range(255, 0)));
          send(gld_pkg::OP_FEED, 8'($urandom_range(255, 0)));
        end
      end
    end
    if (post_noise) begin
      request(s);
      repeat (5) send(gld_pkg::OP_FEED, 8'($urandom_range(255, 0)));
    end
  endtask

  task automatic run_stream(int cfg_val, int npix, int alpha, bit bad_first, bit mid_clear,
                            bit with_loop, bit premature, bit post_noise);
    int a;
    settle();
    if (cfg_val >= 0) write_cfg(cfg_val);
    send(gld_pkg::OP_RESTART, 8'($urandom_range(255, 0)));
    enc_m = clamp_size(cur_cfg);
    stream_bytes.delete();
    enc_acc = 0;
    enc_bits = 0;
    enc_reload();
    if (with_loop && enc_m >= 2) enc_loop();
    a = (alpha > (1 << enc_m)) ? (1 << enc_m) : alpha;
    enc_lzw(npix, a, bad_first, mid_clear);
    if (!premature) enc_code((1 << enc_m) + 1);
    if (enc_bits > 0) stream_bytes.push_back(enc_acc[7:0]);
    play(post_noise);
    streams++;
  endtask

  initial begin
    int v;
    rst = 1'b1;
    start = 1'b0;
    op = gld_pkg::OP_FEED;
    data_byte = '0;
    cfg_valid = 1'b0;
    cfg_data = gld_pkg::MIN_SIZE_RESET;
    items_sent = 0;
    streams = 0;
    no_idle = 1'b0;
    cur_cfg = int'(gld_pkg::MIN_SIZE_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all-zero/all-max pixels with a bad first code, then refusals after the end.
    run_stream(8, 10, 0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    // Register below the legal range acts as one bit, with a clear mid-stream.
    run_stream(0, 8, 2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    // Chain loop.
    run_stream(4, 4, 16, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    // Register above the legal range; stream cut short before the end code.
    run_stream(15, 5, 256, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);

    // Random: one long stream to grow the code width, then a mix.
    run_stream(1, 350, 2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    while (items_sent < 700) begin
      no_idle = ($urandom_range(4, 0) == 0);
      v = $urandom_range(1, 0) ? $urandom_range(15, 0) : -1;
      run_stream(v, $urandom_range(40, 2), $urandom_range(1, 0) ? $urandom_range(4, 0) : 256,
                 $urandom_range(9, 0) == 0, $urandom_range(5, 0) == 0,
                 $urandom_range(12, 0) == 0, $urandom_range(6, 0) == 0,
                 $urandom_range(3, 0) == 0);
    end

    settle();
    repeat (20) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    $display("summary: %0d items over %0d streams, %0d results checked", items_sent, streams,
             checked);
    $display("covered min code sizes 0..15, clears, bad first codes, loops, refused feeds");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
